// File: hdl/adaptive_window_arq_sender_unit_defines.svh
// Assertion macros used by the checker file of the ARQ sender.
`ifndef ADAPTIVE_WINDOW_ARQ_SENDER_UNIT_DEFINES_SVH
`define ADAPTIVE_WINDOW_ARQ_SENDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AWAS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("awas checker: implication violated");

// Next-cycle implication, disabled during reset.
`define AWAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("awas checker: next-cycle implication violated");

`endif

// File: hdl/awas_pkg.sv
// Types, codes and checksum function of the ARQ sender.
`timescale 1ns / 1ps
`default_nettype none
package awas_pkg;

   localparam logic [2:0] OP_OPEN  = 3'd0;
   localparam logic [2:0] OP_SEND  = 3'd1;
   localparam logic [2:0] OP_CLOSE = 3'd2;
   localparam logic [2:0] OP_RECV  = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;

   localparam logic [2:0] PKT_SYN    = 3'd0;
   localparam logic [2:0] PKT_SYNACK = 3'd1;
   localparam logic [2:0] PKT_ACK    = 3'd2;
   localparam logic [2:0] PKT_DATA   = 3'd4;
   localparam logic [2:0] PKT_FIN    = 3'd5;
   localparam logic [2:0] PKT_FINACK = 3'd6;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_WINDOW_FULL = 3'd1;
   localparam logic [2:0] ST_BAD_SUM     = 3'd2;
   localparam logic [2:0] ST_LINK_LOST   = 3'd3;
   localparam logic [2:0] ST_WRONG_PHASE = 3'd4;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_WAITSYN = 2'd1;
   localparam logic [1:0] PH_OPEN    = 2'd2;
   localparam logic [1:0] PH_WAITFIN = 2'd3;

   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_RESENDS = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [3:0]  RESENDS_RESET = 4'd5;
   localparam logic [3:0]  RESEND_SAT    = 4'd15;
   localparam logic [7:0]  SYN_SEQ       = 8'd1;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  data_byte;
      logic [7:0]  start_seq;
      logic [2:0]  rx_type;
      logic [7:0]  rx_seq;
      logic [15:0] rx_checksum;
   } req_type;

   typedef struct packed {
      logic [2:0] ptype;
      logic [7:0] seq;
      logic [7:0] payload;
   } hist_type;

   typedef struct packed {
      logic        packet_valid;
      logic [2:0]  out_type;
      logic [7:0]  out_seq;
      logic [15:0] out_checksum;
      logic [7:0]  out_data;
      logic [2:0]  status;
      logic [1:0]  link_phase;
      logic        fast_mode;
      logic        last_of_run;
   } result_type;

   // Sum never exceeds 517, so the end-around carry never fires.
   function automatic logic [15:0] pkt_sum(logic [2:0] t, logic [7:0] s, logic [7:0] b);
      logic [9:0] sum;
      sum = {7'd0, t} + {2'd0, s};
      if (t == PKT_DATA) begin
         sum = sum + {2'd0, b};
      end
      return ~{6'd0, sum};
   endfunction

endpackage
`default_nettype wire

// File: hdl/adaptive_window_arq_sender_unit.sv
// Top level of the ARQ sender: input register, control registers, core and result queue.
//
//   channel   dir   beat contents
//   req_*     in    one operation (open, send, close, received packet, tick)
//   rsp_*     out   one result; a fast-mode expiry gives two beats, tlast on the second
//   csr_*     in    APB writes and reads of timeout_ticks (0x0) and max_resends (0x4)
//
// One operation per cycle while the queue has room: input register, then one pass of logic
// into the result queue; the first rsp beat comes from a queue slot.
// A fast-mode expiry needs both queue entries free, so it may wait for the queue to drain.
// Reset is synchronous, active high; it clears the link state and the send history.
// Stalls on rsp back up through the queue into req_tready.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_window_arq_sender_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // data_byte, start_seq, rx_type, rx_seq, rx_checksum
   input  wire logic [2:0]  req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // type, seq, checksum, data, status, link_phase, fast_mode
   output logic             rsp_tuser,   // packet_valid
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                 in_valid_ff, in_valid_in;
   awas_pkg::req_type    in_req_ff;
   logic [15:0]          timeout_ff;
   logic [3:0]           resends_ff;
   logic                 fire, two;
   logic [1:0]           free_slots;
   awas_pkg::result_type res0, res1, head;

   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         awas_pkg::REG_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         awas_pkg::REG_RESENDS: csr_prdata = {28'd0, resends_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= awas_pkg::TIMEOUT_RESET;
         resends_ff <= awas_pkg::RESENDS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == awas_pkg::REG_TIMEOUT) begin
            timeout_ff <= csr_pwdata[15:0];
         end else begin
            resends_ff <= csr_pwdata[3:0];
         end
      end
   end

   // advance only when the queue has room for every result of this beat
   assign fire        = in_valid_ff && (two ? (free_slots == 2'd2) : (free_slots != 2'd0));
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff <= '{op: req_tuser, data_byte: req_tdata[7:0],
                        start_seq: req_tdata[15:8], rx_type: req_tdata[18:16],
                        rx_seq: req_tdata[26:19], rx_checksum: req_tdata[42:27]};
      end
   end

   awas_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .req           (in_req_ff),
      .timeout_ticks (timeout_ff),
      .max_resends   (resends_ff),
      .res0          (res0),
      .res1          (res1),
      .two           (two)
   );

   awas_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .push_two   (two),
      .res0       (res0),
      .res1       (res1),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .free_slots (free_slots)
   );

   assign rsp_tuser = head.packet_valid;
   assign rsp_tlast = head.last_of_run;
   assign rsp_tdata = {7'd0, head.fast_mode, head.link_phase, head.status, head.out_data,
                       head.out_checksum, head.out_seq, head.out_type};

endmodule
`default_nettype wire

// File: hdl/awas_core.sv
// Protocol state and single-pass next-state and result logic of the ARQ sender.
`timescale 1ns / 1ps
`default_nettype none
module awas_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire awas_pkg::req_type    req,
   input  wire logic [15:0]          timeout_ticks,
   input  wire logic [3:0]           max_resends,
   output awas_pkg::result_type      res0,
   output awas_pkg::result_type      res1,
   output logic                      two
);

   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         base_ff, base_in;
   logic [7:0]         next_seq_ff, next_seq_in;
   logic               fast_ff, fast_in;
   logic [3:0]         resend_ff, resend_in;
   logic [15:0]        timer_left_ff, timer_left_in;
   logic               timer_run_ff, timer_run_in;
   awas_pkg::hist_type hist0_ff, hist0_in;
   awas_pkg::hist_type hist1_ff, hist1_in;

   logic               pkt0_v, pkt1_v;
   awas_pkg::hist_type pkt0, pkt1;
   logic [2:0]         status;
   logic [7:0]         span, nb;
   logic [3:0]         cnt_inc;

   function automatic awas_pkg::result_type make_result(
      logic v, awas_pkg::hist_type h, logic [2:0] st, logic [1:0] ph, logic f, logic last);
      awas_pkg::result_type r;
      r = '0;
      if (v) begin
         r.packet_valid = 1'b1;
         r.out_type     = h.ptype;
         r.out_seq      = h.seq;
         r.out_checksum = awas_pkg::pkt_sum(h.ptype, h.seq, h.payload);
         r.out_data     = (h.ptype == awas_pkg::PKT_DATA) ? h.payload : 8'd0;
      end
      r.status      = st;
      r.link_phase  = ph;
      r.fast_mode   = f;
      r.last_of_run = last;
      return r;
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      base_in       = base_ff;
      next_seq_in   = next_seq_ff;
      fast_in       = fast_ff;
      resend_in     = resend_ff;
      timer_left_in = timer_left_ff;
      timer_run_in  = timer_run_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      status        = awas_pkg::ST_OK;
      pkt0_v        = 1'b0;
      pkt1_v        = 1'b0;
      pkt0          = '0;
      pkt1          = '0;
      two           = 1'b0;
      span          = next_seq_ff - base_ff;
      nb            = req.rx_seq + 8'd1;
      cnt_inc       = (resend_ff == awas_pkg::RESEND_SAT) ? awas_pkg::RESEND_SAT
                                                          : resend_ff + 4'd1;
      unique case (req.op)
         awas_pkg::OP_OPEN: begin
            if (phase_ff != awas_pkg::PH_IDLE) begin
               status = awas_pkg::ST_WRONG_PHASE;
            end else begin
               pkt0_v        = 1'b1;
               pkt0          = '{ptype: awas_pkg::PKT_SYN, seq: awas_pkg::SYN_SEQ,
                                 payload: 8'd0};
               hist1_in      = hist0_ff;
               hist0_in      = pkt0;
               base_in       = req.start_seq;
               next_seq_in   = req.start_seq;
               phase_in      = awas_pkg::PH_WAITSYN;
               resend_in     = 4'd0;
               timer_left_in = timeout_ticks;
               timer_run_in  = 1'b1;
            end
         end
         awas_pkg::OP_SEND: begin
            if (phase_ff != awas_pkg::PH_OPEN) begin
               status = awas_pkg::ST_WRONG_PHASE;
            end else if (span >= {7'd0, fast_ff} + 8'd1) begin
               status = awas_pkg::ST_WINDOW_FULL;
            end else begin
               pkt0_v = 1'b1;
               pkt0   = '{ptype: awas_pkg::PKT_DATA, seq: next_seq_ff,
                          payload: req.data_byte};
               if (base_ff == next_seq_ff) begin
                  resend_in     = 4'd0;
                  timer_left_in = timeout_ticks;
                  timer_run_in  = 1'b1;
               end
               hist1_in    = hist0_ff;
               hist0_in    = pkt0;
               next_seq_in = next_seq_ff + 8'd1;
            end
         end
         awas_pkg::OP_CLOSE: begin
            if (phase_ff != awas_pkg::PH_OPEN) begin
               status = awas_pkg::ST_WRONG_PHASE;
            end else begin
               pkt0_v        = 1'b1;
               pkt0          = '{ptype: awas_pkg::PKT_FIN, seq: next_seq_ff, payload: 8'd0};
               hist1_in      = hist0_ff;
               hist0_in      = pkt0;
               phase_in      = awas_pkg::PH_WAITFIN;
               resend_in     = 4'd0;
               timer_left_in = timeout_ticks;
               timer_run_in  = 1'b1;
            end
         end
         awas_pkg::OP_RECV: begin
            if (awas_pkg::pkt_sum(req.rx_type, req.rx_seq, req.data_byte)
                != req.rx_checksum) begin
               status = awas_pkg::ST_BAD_SUM;
            end else if (phase_ff == awas_pkg::PH_WAITSYN
                         && req.rx_type == awas_pkg::PKT_SYNACK) begin
               phase_in      = awas_pkg::PH_OPEN;
               timer_left_in = 16'd0;
               timer_run_in  = 1'b0;
               resend_in     = 4'd0;
            end else if (phase_ff == awas_pkg::PH_WAITFIN
                         && req.rx_type == awas_pkg::PKT_FINACK) begin
               phase_in      = awas_pkg::PH_IDLE;
               timer_left_in = 16'd0;
               timer_run_in  = 1'b0;
               resend_in     = 4'd0;
            end else if (phase_ff == awas_pkg::PH_OPEN
                         && req.rx_type == awas_pkg::PKT_ACK) begin
               // accept only an ack that lands inside the outstanding span
               if (8'(nb - base_ff) <= span) begin
                  base_in = nb;
                  if (nb == next_seq_ff) begin
                     timer_left_in = 16'd0;
                     timer_run_in  = 1'b0;
                     resend_in     = 4'd0;
                     fast_in       = 1'b1;
                  end else begin
                     timer_left_in = timeout_ticks;
                     timer_run_in  = 1'b1;
                  end
               end
            end
         end
         awas_pkg::OP_TICK: begin
            if (timer_run_ff) begin
               if (timer_left_ff > 16'd1) begin
                  timer_left_in = timer_left_ff - 16'd1;
               end else if (cnt_inc >= max_resends) begin
                  status        = awas_pkg::ST_LINK_LOST;
                  phase_in      = awas_pkg::PH_IDLE;
                  timer_left_in = 16'd0;
                  timer_run_in  = 1'b0;
                  fast_in       = 1'b0;
                  resend_in     = 4'd0;
               end else begin
                  // resend newest first, then the older one in fast mode
                  resend_in     = cnt_inc;
                  pkt0_v        = 1'b1;
                  pkt0          = hist0_ff;
                  pkt1_v        = fast_ff;
                  pkt1          = hist1_ff;
                  two           = fast_ff;
                  fast_in       = 1'b0;
                  timer_left_in = timeout_ticks;
                  timer_run_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      res0 = make_result(pkt0_v, pkt0, status, phase_in, fast_in, !two);
      res1 = make_result(pkt1_v, pkt1, status, phase_in, fast_in, 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= awas_pkg::PH_IDLE;
         base_ff       <= 8'd0;
         next_seq_ff   <= 8'd0;
         fast_ff       <= 1'b0;
         resend_ff     <= 4'd0;
         timer_left_ff <= 16'd0;
         timer_run_ff  <= 1'b0;
         hist0_ff      <= '0;
         hist1_ff      <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         base_ff       <= base_in;
         next_seq_ff   <= next_seq_in;
         fast_ff       <= fast_in;
         resend_ff     <= resend_in;
         timer_left_ff <= timer_left_in;
         timer_run_ff  <= timer_run_in;
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/awas_out_queue.sv
// Two-entry result queue that takes one or two results per cycle.
`timescale 1ns / 1ps
`default_nettype none
module awas_out_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic                 push_two,
   input  wire awas_pkg::result_type res0,
   input  wire awas_pkg::result_type res1,
   input  wire logic                 pop_ready,
   output logic                      head_valid,
   output awas_pkg::result_type      head,
   output logic [1:0]                free_slots
);

   awas_pkg::result_type slot0_ff, slot0_in;
   awas_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;
   logic [1:0]           after;
   logic                 pop;

   assign head_valid = (count_ff != 2'd0);
   assign head       = slot0_ff;

   always_comb begin
      pop        = head_valid && pop_ready;
      after      = count_ff - {1'b0, pop};
      free_slots = 2'd2 - after;
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      count_in   = after;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (after == 2'd0) begin
            slot0_in = res0;
            if (push_two) begin
               slot1_in = res1;
            end
         end else begin
            slot1_in = res0;
         end
         count_in = after + (push_two ? 2'd2 : 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule
`default_nettype wire

// File: hdl/awas_checker.sv
// Port-level checker for the ARQ sender and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_window_arq_sender_unit_defines.svh"
module awas_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   logic [2:0] rsp_status;
   logic [1:0] rsp_phase;
   logic       rsp_fast;
   logic       rsp_lost;
   logic       rsp_ok;
   logic       rsp_idle;

   assign rsp_status = rsp_tdata[37:35];
   assign rsp_phase  = rsp_tdata[39:38];
   assign rsp_fast   = rsp_tdata[40];
   assign rsp_lost   = (rsp_status == awas_pkg::ST_LINK_LOST);
   assign rsp_ok     = (rsp_status == awas_pkg::ST_OK);
   assign rsp_idle   = (rsp_phase == awas_pkg::PH_IDLE);

   // a stalled beat holds
   `AWAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // a beat without a packet carries an all-zero packet
   `AWAS_ASSERT_IMPLY(a_empty_pkt, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[34:0] == 35'd0)
   // a lost link leaves the sender idle and slow
   `AWAS_ASSERT_IMPLY(a_lost_idle, clock, reset, rsp_tvalid && rsp_lost, rsp_idle && !rsp_fast && !rsp_tuser)
   // only the first half of an expiry pair is not last
   `AWAS_ASSERT_IMPLY(a_pair_first, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser && !rsp_fast && rsp_ok)

endmodule

bind adaptive_window_arq_sender_unit awas_checker u_awas_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
